/* rtl/core/rhht_pkg.sv */
// ---------------------------------------------------------------------------
// Robin Hood hash table package
// Shared types, sizes and codes for the hash table core.
// ---------------------------------------------------------------------------
package rhht_pkg;

    localparam int CAPACITY   = 64;
    localparam int VALUE_BITS = 32;
    localparam int SLOT_BITS  = $clog2(CAPACITY);
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);
    localparam int KEY_BITS   = 64;
    localparam int LEN_BITS   = 4;
    // Slot word: used, distance, key length, key, value.
    localparam int SLOT_W = 1 + SLOT_BITS + LEN_BITS + KEY_BITS + VALUE_BITS;

    typedef enum logic [1:0] {
        CMD_GET = 2'd0,
        CMD_SET = 2'd1,
        CMD_DEL = 2'd2,
        CMD_NOP = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2,
        ST_RSVD = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [KEY_BITS-1:0] lookup_key;
        logic [LEN_BITS-1:0] key_len;
        logic [31:0]         key_hash;
        logic [31:0]         set_value;
    } req_t;

    typedef struct packed {
        logic [1:0]            status;
        logic                  hit;
        logic [31:0]           read_value;
        logic [6:0]            entry_count;
    } rsp_t;

    typedef struct packed {
        logic                  used;
        logic [SLOT_BITS-1:0]  distance;
        logic [LEN_BITS-1:0]   len;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } slot_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CHK,
        S_INS_RD,
        S_INS_CHK,
        S_DEL_RD,
        S_DEL_CHK,
        S_DONE
    } state_t;

    // Slot-word compare result handed from the compare unit to the sequencer.
    typedef struct packed {
        logic stop_find;
        logic match;
        logic richer;
    } cmp_t;

    function automatic logic [KEY_BITS-1:0] mask_key(logic [KEY_BITS-1:0] key,
                                                     logic [LEN_BITS-1:0] len);
        logic [KEY_BITS-1:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (len > LEN_BITS'(i))
            begin
                m[i*8 +: 8] = 8'hFF;
            end
        end
        return key & m;
    endfunction

endpackage

/* rtl/core/rhht_ram.sv */
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module rhht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/rhht_cmp.sv */
// ---------------------------------------------------------------------------
// Slot compare unit
// Compares one slot word against the probe key and probe distance.
// ---------------------------------------------------------------------------
module rhht_cmp (
    input  rhht_pkg::slot_t                  slot,
    input  logic [rhht_pkg::KEY_BITS-1:0]    key,
    input  logic [rhht_pkg::LEN_BITS-1:0]    len,
    input  logic [rhht_pkg::SLOT_BITS:0]     probe,
    output rhht_pkg::cmp_t                   res
);

    logic [rhht_pkg::SLOT_BITS:0] sd;

    always_comb
    begin
        sd            = {1'b0, slot.distance};
        res.richer    = sd < probe;
        res.stop_find = !slot.used || (sd < probe);
        res.match     = slot.used && (sd == probe) && (slot.len == len)
                        && (slot.key == key);
    end

endmodule

/* rtl/core/robin_hood_hash_table_core.sv */
// ---------------------------------------------------------------------------
// Robin Hood hash table core
// Fixed-capacity open-addressing table with backward-shift delete.
// ---------------------------------------------------------------------------
// A command beat is taken at a rising edge where start is high and busy is
// low. The block then walks the table slot by slot, each slot in a read
// state and a check state: a read of the slot RAM, then a compare and
// possibly a write-back. A set of a new key walks again from the home slot
// up to and including the empty slot, and a delete walks each entry shifted
// back plus the slot that ends the shift. An unused command code goes
// straight to the result beat. busy stays high through the result cycle, so
// the next command beat can be taken in the cycle after the result beat.
// The result beat shows for one cycle with done high; the receiver cannot
// stall it. After reset the table is empty: the used bits live in flip-flops
// cleared by reset and the rest of each slot lives in the RAM, so no
// clearing pass is needed and a command can be given at once.
// ---------------------------------------------------------------------------
module robin_hood_hash_table_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  rhht_pkg::req_t   req,
    output logic             done,
    output rhht_pkg::rsp_t   rsp
);

    localparam int SB = rhht_pkg::SLOT_BITS;

    rhht_pkg::state_t state_reg, state_next;

    logic [rhht_pkg::CAPACITY-1:0] used_reg, used_next;
    logic [rhht_pkg::COUNT_BITS-1:0] count_reg, count_next;

    logic [1:0]                       cmd_reg, cmd_next;
    logic [rhht_pkg::KEY_BITS-1:0]    key_reg, key_next;
    logic [rhht_pkg::LEN_BITS-1:0]    len_reg, len_next;
    logic [rhht_pkg::VALUE_BITS-1:0]  val_reg, val_next;
    logic [SB-1:0]                    slot_reg, slot_next;
    logic [SB:0]                      d_reg, d_next;
    logic [SB:0]                      n_reg, n_next;
    logic [SB-1:0]                    home_reg, home_next;
    rhht_pkg::rsp_t                   rsp_reg, rsp_next;
    logic                             done_reg, done_next;

    logic                   we;
    logic [SB-1:0]          waddr, raddr;
    rhht_pkg::slot_t        wslot, rword, cur;
    rhht_pkg::cmp_t         cres;
    logic [SB-1:0]          slot_inc;

    rhht_ram #(.WIDTH(rhht_pkg::SLOT_W), .DEPTH(rhht_pkg::CAPACITY)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wslot),
        .raddr (raddr),
        .rdata (rword)
    );

    // Used comes from flip-flops; the RAM holds distance and payload.
    always_comb
    begin
        cur       = rword;
        cur.used  = used_reg[slot_reg];
    end

    rhht_cmp u_cmp (
        .slot  (cur),
        .key   (key_reg),
        .len   (len_reg),
        .probe (d_reg),
        .res   (cres)
    );

    assign slot_inc = slot_reg + SB'(1);
    assign raddr    = slot_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rhht_pkg::S_IDLE;
            used_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        key_reg  <= key_next;
        len_reg  <= len_next;
        val_reg  <= val_next;
        slot_reg <= slot_next;
        d_reg    <= d_next;
        n_reg    <= n_next;
        home_reg <= home_next;
        rsp_reg  <= rsp_next;
    end

    always_comb
    begin
        state_next = state_reg;
        used_next  = used_reg;
        count_next = count_reg;
        cmd_next   = cmd_reg;
        key_next   = key_reg;
        len_next   = len_reg;
        val_next   = val_reg;
        slot_next  = slot_reg;
        d_next     = d_reg;
        n_next     = n_reg;
        home_next  = home_reg;
        rsp_next   = rsp_reg;
        done_next  = 1'b0;
        we         = 1'b0;
        waddr      = slot_reg;
        wslot      = cur;

        unique case (state_reg)
            rhht_pkg::S_IDLE:
            begin
                if (start && !busy)
                begin
                    cmd_next  = req.cmd;
                    key_next  = rhht_pkg::mask_key(req.lookup_key, req.key_len);
                    len_next  = req.key_len;
                    val_next  = rhht_pkg::VALUE_BITS'(req.set_value);
                    home_next = req.key_hash[SB-1:0];
                    slot_next = req.key_hash[SB-1:0];
                    d_next    = '0;
                    n_next    = '0;
                    rsp_next  = '0;
                    if (req.cmd == rhht_pkg::CMD_NOP)
                    begin
                        state_next = rhht_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = rhht_pkg::S_FIND_RD;
                    end
                end
            end

            rhht_pkg::S_FIND_RD:
            begin
                state_next = rhht_pkg::S_FIND_CHK;
            end

            rhht_pkg::S_FIND_CHK:
            begin
                if (cres.match)
                begin
                    rsp_next.hit = 1'b1;
                    unique case (cmd_reg)
                        rhht_pkg::CMD_GET:
                        begin
                            rsp_next.read_value = 32'(rword.value);
                            state_next = rhht_pkg::S_DONE;
                        end
                        rhht_pkg::CMD_SET:
                        begin
                            we          = 1'b1;
                            wslot       = cur;
                            wslot.value = val_reg;
                            state_next  = rhht_pkg::S_DONE;
                        end
                        default:
                        begin
                            // Delete: free this slot and start the back shift.
                            used_next[slot_reg] = 1'b0;
                            count_next = count_reg - rhht_pkg::COUNT_BITS'(1);
                            n_next     = (SB+1)'(1);
                            slot_next  = slot_inc;
                            state_next = rhht_pkg::S_DEL_RD;
                        end
                    endcase
                end
                else if (cres.stop_find
                         || d_reg == (SB+1)'(rhht_pkg::CAPACITY - 1))
                begin
                    unique case (cmd_reg)
                        rhht_pkg::CMD_GET:
                        begin
                            rsp_next.status = rhht_pkg::ST_MISS;
                            state_next = rhht_pkg::S_DONE;
                        end
                        rhht_pkg::CMD_SET:
                        begin
                            if (count_reg >= rhht_pkg::COUNT_BITS'(rhht_pkg::CAPACITY))
                            begin
                                rsp_next.status = rhht_pkg::ST_FULL;
                                state_next = rhht_pkg::S_DONE;
                            end
                            else
                            begin
                                slot_next  = home_reg;
                                d_next     = '0;
                                state_next = rhht_pkg::S_INS_RD;
                            end
                        end
                        default:
                        begin
                            state_next = rhht_pkg::S_DONE;
                        end
                    endcase
                end
                else
                begin
                    d_next     = d_reg + (SB+1)'(1);
                    slot_next  = slot_inc;
                    state_next = rhht_pkg::S_FIND_RD;
                end
            end

            rhht_pkg::S_INS_RD:
            begin
                state_next = rhht_pkg::S_INS_CHK;
            end

            rhht_pkg::S_INS_CHK:
            begin
                wslot.used     = 1'b1;
                wslot.distance = d_reg[SB-1:0];
                wslot.len      = len_reg;
                wslot.key      = key_reg;
                wslot.value    = val_reg;
                if (!cur.used)
                begin
                    we = 1'b1;
                    used_next[slot_reg] = 1'b1;
                    count_next = count_reg + rhht_pkg::COUNT_BITS'(1);
                    state_next = rhht_pkg::S_DONE;
                end
                else
                begin
                    if (cres.richer)
                    begin
                        // Swap the carried entry with the richer resident.
                        we = 1'b1;
                        key_next = rword.key;
                        len_next = rword.len;
                        val_next = rword.value;
                        d_next   = {1'b0, cur.distance} + (SB+1)'(1);
                    end
                    else
                    begin
                        d_next = d_reg + (SB+1)'(1);
                    end
                    slot_next  = slot_inc;
                    state_next = rhht_pkg::S_INS_RD;
                end
            end

            rhht_pkg::S_DEL_RD:
            begin
                state_next = rhht_pkg::S_DEL_CHK;
            end

            rhht_pkg::S_DEL_CHK:
            begin
                // slot_reg is the next slot; the previous one is one behind.
                if (!cur.used || cur.distance == '0
                    || n_reg == (SB+1)'(rhht_pkg::CAPACITY))
                begin
                    state_next = rhht_pkg::S_DONE;
                end
                else
                begin
                    we             = 1'b1;
                    waddr          = slot_reg - SB'(1);
                    wslot          = cur;
                    wslot.distance = cur.distance - SB'(1);
                    used_next[waddr]    = 1'b1;
                    used_next[slot_reg] = 1'b0;
                    n_next     = n_reg + (SB+1)'(1);
                    slot_next  = slot_inc;
                    state_next = rhht_pkg::S_DEL_RD;
                end
            end

            rhht_pkg::S_DONE:
            begin
                rsp_next.entry_count = 7'(count_reg);
                done_next  = 1'b1;
                state_next = rhht_pkg::S_IDLE;
            end

            default:
            begin
                state_next = rhht_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != rhht_pkg::S_IDLE) || done_reg;
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

/* rtl/core/rhht_checker.sv */
// ---------------------------------------------------------------------------
// Hash table port checker
// Watches the command and result beats of the core.
// ---------------------------------------------------------------------------
module rhht_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input rhht_pkg::rsp_t rsp
);

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after a command beat");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result beat while not busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat lasted two cycles");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.status != rhht_pkg::ST_RSVD && rsp.entry_count <= 7'd64))
        else $error("illegal result fields");

endmodule

bind robin_hood_hash_table_core rhht_checker u_rhht_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);
